// File: design/median_band_mean_hysteresis_filter_top_macros.svh
// ----------------------------------------------------------------------------
// median band mean filter assertion macros
// concurrent assertion shorthands shared by the filter rtl
// ----------------------------------------------------------------------------
`ifndef MEDIAN_BAND_MEAN_HYSTERESIS_FILTER_TOP_MACROS_SVH
`define MEDIAN_BAND_MEAN_HYSTERESIS_FILTER_TOP_MACROS_SVH

// same-cycle implication
`define MBMH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MBMH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/mbmh_pkg.sv
// ----------------------------------------------------------------------------
// median band mean filter package
// shared widths, register map, defaults and helper function
// ----------------------------------------------------------------------------
package mbmh_pkg;

   // field widths
   localparam int unsigned SAMPLE_W  = 24;
   localparam int unsigned GRADE_W   = 4;
   localparam int unsigned BAND_W    = 16;
   localparam int unsigned EDGE_W    = 24;
   localparam int unsigned HOLD_W    = 6;

   // parameter defaults
   localparam int unsigned GRADE_MAX_DEF  = 13;
   localparam int unsigned HOLD_LIMIT_DEF = 50;

   // window size is base plus step times grade
   localparam int unsigned SIZE_BASE = 4;
   localparam int unsigned SIZE_STEP = 2;

   // configuration port
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REG_IDX_W  = 2;
   localparam logic [REG_IDX_W-1:0] REG_GRADE = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_BAND  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_EDGE  = 2'd2;
   localparam logic [GRADE_W-1:0]   GRADE_RST = 4'd13;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [SAMPLE_W:0]          mag_type;

   // magnitude of the difference of two samples
   function automatic mag_type abs_diff(sample_type a, sample_type b);
      logic signed [SAMPLE_W:0] d;
      d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
      return d[SAMPLE_W] ? mag_type'(-d) : mag_type'(d);
   endfunction

endpackage

// File: design/mbmh_if.sv
// ----------------------------------------------------------------------------
// median band mean filter channels
// valid/ready request and result channels
// ----------------------------------------------------------------------------
interface mbmh_req_if;
   logic                 valid;
   logic                 ready;
   logic                 operation;
   mbmh_pkg::sample_type sample;
   modport source (output valid, operation, sample, input ready);
   modport sink (input valid, operation, sample, output ready);
endinterface

interface mbmh_rsp_if;
   logic                 valid;
   logic                 ready;
   mbmh_pkg::sample_type filtered;
   logic                 stable;
   modport source (output valid, filtered, stable, input ready);
   modport sink (input valid, filtered, stable, output ready);
endinterface

// File: design/median_band_mean_hysteresis_filter_top.sv
// ----------------------------------------------------------------------------
// median band mean hysteresis filter
// weigh-scale sample filter: step pass, settling average, median band mean
// ----------------------------------------------------------------------------
// Takes one request at a time and returns one result per request. A step or
// settling sample passes the write, decide and output states before its
// result is offered (a prime first writes size window entries). A filtered
// sample finds the upper median by ranking candidates against the window
// with one compare unit reading the window memory one entry per cycle; the
// band mean then uses an iterative divider at one quotient bit per cycle.
// The window resets to zero through per-entry valid bits, so no clearing
// pass is needed after reset.
// Configuration must only be written while the block is idle; writes are not
// held off while a request is in work.
`include "median_band_mean_hysteresis_filter_top_macros.svh"

module median_band_mean_hysteresis_filter_top #(
   parameter int unsigned GRADE_MAX  = mbmh_pkg::GRADE_MAX_DEF,
   parameter int unsigned HOLD_LIMIT = mbmh_pkg::HOLD_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   mbmh_req_if.sink                          req_chan,
   mbmh_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mbmh_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mbmh_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mbmh_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   localparam int unsigned SW     = mbmh_pkg::SAMPLE_W;
   localparam int unsigned DEPTH  = mbmh_pkg::SIZE_BASE + mbmh_pkg::SIZE_STEP * GRADE_MAX;
   localparam int unsigned IDX_W  = $clog2(DEPTH);
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W  = SW + CNT_W;
   localparam int unsigned GS_W   = $clog2(GRADE_MAX * DEPTH + 2);
   localparam int unsigned THR_W  = mbmh_pkg::BAND_W + GS_W;
   localparam int unsigned TH_W   = (THR_W > mbmh_pkg::EDGE_W) ? THR_W : mbmh_pkg::EDGE_W;
   localparam int unsigned CMP_W  = TH_W + SW + 1;
   localparam int unsigned GW     = mbmh_pkg::GRADE_W;
   localparam int unsigned HW     = mbmh_pkg::HOLD_W;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FILL  = 4'd1;
   localparam logic [3:0] S_WRITE = 4'd2;
   localparam logic [3:0] S_DEC   = 4'd3;
   localparam logic [3:0] S_CAND  = 4'd4;
   localparam logic [3:0] S_CLOAD = 4'd5;
   localparam logic [3:0] S_MSCAN = 4'd6;
   localparam logic [3:0] S_ASCAN = 4'd7;
   localparam logic [3:0] S_DIVGO = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_HYST  = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;

   // configuration registers
   logic [GW-1:0]                    grade_ff;
   logic [mbmh_pkg::BAND_W-1:0]      band_ff;
   logic [mbmh_pkg::EDGE_W-1:0]      edge_ff;
   logic [mbmh_pkg::REG_IDX_W-1:0]   reg_idx;
   logic                             csr_wr;

   // sequencer and datapath registers
   logic [3:0]           state_ff, state_in;
   mbmh_pkg::sample_type smp_ff, smp_in;
   logic [CNT_W-1:0]     size_ff, size_in;
   logic [GS_W-1:0]      gs_ff, gs_in;
   logic [THR_W-1:0]     thr_ff, thr_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [CNT_W-1:0]     j_ff, j_in;
   logic                 pv_ff, pv_in;
   mbmh_pkg::sample_type cand_ff, cand_in;
   logic [CNT_W-1:0]     lt_ff, lt_in;
   logic [CNT_W-1:0]     le_ff, le_in;
   mbmh_pkg::sample_type med_ff, med_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [IDX_W-1:0]     wp_ff, wp_in;
   mbmh_pkg::sample_type held_ff, held_in;
   logic [CNT_W-1:0]     settle_ff, settle_in;
   logic [HW-1:0]        hold_ff, hold_in;
   mbmh_pkg::sample_type mean_ff, mean_in;
   mbmh_pkg::sample_type res_ff, res_in;
   logic                 stb_ff, stb_in;
   logic                 rv_ff, rv_in;
   mbmh_pkg::sample_type rf_ff, rf_in;
   logic                 rs_ff, rs_in;

   // window memory
   mbmh_pkg::sample_type mem [DEPTH];
   logic [DEPTH-1:0]     vld_ff;
   mbmh_pkg::sample_type rd_raw_ff;
   logic                 rd_vld_ff;
   mbmh_pkg::sample_type rd_data;
   logic                 we;
   logic [IDX_W-1:0]     wa;
   logic                 re;
   logic [IDX_W-1:0]     ra;

   // misc combinational
   logic [GW-1:0]        g_clamp;
   logic [CNT_W-1:0]     size_c;
   logic [CNT_W-1:0]     k_rank;
   logic [CNT_W-1:0]     wp_next;
   logic [TH_W-1:0]      thr_max;
   logic                 step_hit;
   logic signed [SW:0]   avg_sum;
   logic [CNT_W-1:0]     lt_n, le_n, cnt_n;
   logic signed [SUM_W-1:0] sum_n;
   logic                 in_band;
   mbmh_pkg::mag_type    hdiff;
   logic [HW-1:0]        hold_inc;
   logic                 div_start;
   logic                 div_done;
   logic [SUM_W-1:0]     div_q;
   logic [SUM_W-1:0]     div_n;
   logic [CNT_W-1:0]     div_d;
   logic [SUM_W-1:0]     q_signed;
   logic                 accept;

   // configuration port
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         grade_ff <= mbmh_pkg::GRADE_RST;
         band_ff  <= '0;
         edge_ff  <= '0;
      end else if (csr_wr) begin
         case (reg_idx)
            mbmh_pkg::REG_GRADE: grade_ff <= csr_pwdata[GW-1:0];
            mbmh_pkg::REG_BAND:  band_ff  <= csr_pwdata[mbmh_pkg::BAND_W-1:0];
            mbmh_pkg::REG_EDGE:  edge_ff  <= csr_pwdata[mbmh_pkg::EDGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         mbmh_pkg::REG_GRADE: csr_prdata = mbmh_pkg::CSR_DATA_W'(grade_ff);
         mbmh_pkg::REG_BAND:  csr_prdata = mbmh_pkg::CSR_DATA_W'(band_ff);
         mbmh_pkg::REG_EDGE:  csr_prdata = mbmh_pkg::CSR_DATA_W'(edge_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // window memory, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= smp_ff;
      end
      if (re) begin
         rd_raw_ff <= mem[ra];
         rd_vld_ff <= vld_ff[ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (we) begin
         vld_ff[wa] <= 1'b1;
      end
   end

   assign rd_data = rd_vld_ff ? rd_raw_ff : '0;

   // iterative divider for the band mean
   assign div_n = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign div_d = (cnt_ff == '0) ? CNT_W'(1) : cnt_ff;

   mbmh_div #(
      .N_W (SUM_W),
      .D_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   // handshake
   assign req_chan.ready  = (state_ff == S_IDLE);
   assign accept          = req_chan.valid && (state_ff == S_IDLE);
   assign rsp_chan.valid    = rv_ff;
   assign rsp_chan.filtered = rf_ff;
   assign rsp_chan.stable   = rs_ff;

   // sequencer
   always_comb begin
      g_clamp  = (grade_ff > GW'(GRADE_MAX)) ? GW'(GRADE_MAX) : grade_ff;
      size_c   = CNT_W'(mbmh_pkg::SIZE_BASE) + CNT_W'(mbmh_pkg::SIZE_STEP) * CNT_W'(g_clamp);
      k_rank   = size_ff >> 1;
      wp_next  = CNT_W'(wp_ff) + 1'b1;
      thr_max  = (TH_W'(edge_ff) > TH_W'(thr_ff)) ? TH_W'(edge_ff) : TH_W'(thr_ff);
      step_hit = CMP_W'(mbmh_pkg::abs_diff(smp_ff, held_ff)) >= CMP_W'(thr_max);
      avg_sum  = {held_ff[SW-1], held_ff} + {smp_ff[SW-1], smp_ff};
      lt_n     = lt_ff + CNT_W'(pv_ff && (rd_data < cand_ff));
      le_n     = le_ff + CNT_W'(pv_ff && (rd_data <= cand_ff));
      in_band  = CMP_W'(mbmh_pkg::abs_diff(med_ff, rd_data)) <= CMP_W'(band_ff);
      sum_n    = (pv_ff && in_band) ?
                 sum_ff + {{(SUM_W-SW){rd_data[SW-1]}}, rd_data} : sum_ff;
      cnt_n    = cnt_ff + CNT_W'(pv_ff && in_band);
      hdiff    = mbmh_pkg::abs_diff(mean_ff, held_ff);
      hold_inc = hold_ff + 1'b1;
      q_signed = neg_ff ? SUM_W'(-div_q) : div_q;

      state_in  = state_ff;
      smp_in    = smp_ff;
      size_in   = size_ff;
      gs_in     = gs_ff;
      thr_in    = thr_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      pv_in     = 1'b0;
      cand_in   = cand_ff;
      lt_in     = lt_ff;
      le_in     = le_ff;
      med_in    = med_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      wp_in     = wp_ff;
      held_in   = held_ff;
      settle_in = settle_ff;
      hold_in   = hold_ff;
      mean_in   = mean_ff;
      res_in    = res_ff;
      stb_in    = stb_ff;
      rv_in     = rv_ff && !rsp_chan.ready;
      rf_in     = rf_ff;
      rs_in     = rs_ff;
      we        = 1'b0;
      wa        = wp_ff;
      re        = 1'b0;
      ra        = j_ff[IDX_W-1:0];
      div_start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               smp_in  = req_chan.sample;
               size_in = size_c;
               gs_in   = GS_W'(g_clamp) * GS_W'(size_c);
               i_in    = '0;
               if (req_chan.operation) begin
                  wp_in    = '0;
                  state_in = S_FILL;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end
         // prime: write the sample into the first size entries
         S_FILL: begin
            we   = 1'b1;
            wa   = i_ff[IDX_W-1:0];
            i_in = i_ff + 1'b1;
            if (i_ff == size_ff - 1'b1) begin
               state_in = S_WRITE;
            end
         end
         // ring write and threshold product
         S_WRITE: begin
            we       = 1'b1;
            wa       = wp_ff;
            wp_in    = (wp_next >= size_ff) ? '0 : wp_next[IDX_W-1:0];
            thr_in   = THR_W'(band_ff) * THR_W'(gs_ff);
            state_in = S_DEC;
         end
         // step, settling or median path
         S_DEC: begin
            if (step_hit) begin
               held_in   = smp_ff;
               settle_in = CNT_W'(1);
               res_in    = smp_ff;
               stb_in    = 1'b0;
               state_in  = S_OUT;
            end else if (settle_ff != '0 && settle_ff <= k_rank) begin
               settle_in = settle_ff + 1'b1;
               held_in   = avg_sum[SW:1];
               res_in    = avg_sum[SW:1];
               stb_in    = 1'b0;
               state_in  = S_OUT;
            end else begin
               i_in     = '0;
               state_in = S_CAND;
            end
         end
         // fetch the next median candidate
         S_CAND: begin
            re       = 1'b1;
            ra       = i_ff[IDX_W-1:0];
            state_in = S_CLOAD;
         end
         S_CLOAD: begin
            cand_in  = rd_data;
            j_in     = '0;
            lt_in    = '0;
            le_in    = '0;
            state_in = S_MSCAN;
         end
         // rank the candidate against the window
         S_MSCAN: begin
            if (j_ff < size_ff) begin
               re    = 1'b1;
               j_in  = j_ff + 1'b1;
               pv_in = 1'b1;
            end
            lt_in = lt_n;
            le_in = le_n;
            if (j_ff == size_ff && pv_ff) begin
               if (lt_n <= k_rank && k_rank < le_n) begin
                  med_in   = cand_ff;
                  j_in     = '0;
                  sum_in   = '0;
                  cnt_in   = '0;
                  state_in = S_ASCAN;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_CAND;
               end
            end
         end
         // accumulate entries within band of the median
         S_ASCAN: begin
            if (j_ff < size_ff) begin
               re    = 1'b1;
               j_in  = j_ff + 1'b1;
               pv_in = 1'b1;
            end
            sum_in = sum_n;
            cnt_in = cnt_n;
            if (j_ff == size_ff && pv_ff) begin
               state_in = S_DIVGO;
            end
         end
         S_DIVGO: begin
            div_start = 1'b1;
            neg_in    = sum_ff[SUM_W-1];
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               mean_in  = q_signed[SW-1:0];
               state_in = S_HYST;
            end
         end
         // two-level hysteresis around the held value
         S_HYST: begin
            if (CMP_W'(hdiff) <= CMP_W'(band_ff >> 2)) begin
               stb_in = 1'b1;
               if (hold_inc >= HW'(HOLD_LIMIT)) begin
                  hold_in = '0;
                  held_in = mean_ff;
                  res_in  = mean_ff;
               end else begin
                  hold_in = hold_inc;
                  res_in  = held_ff;
               end
            end else if (CMP_W'(hdiff) <= CMP_W'(band_ff >> 1)) begin
               stb_in  = 1'b1;
               res_in  = held_ff;
               hold_in = '0;
            end else begin
               stb_in  = 1'b0;
               held_in = mean_ff;
               res_in  = mean_ff;
               hold_in = '0;
            end
            state_in = S_OUT;
         end
         // hand the result to the output register once it is free
         S_OUT: begin
            if (!rv_ff || rsp_chan.ready) begin
               rv_in    = 1'b1;
               rf_in    = res_ff;
               rs_in    = stb_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         wp_ff     <= '0;
         held_ff   <= '0;
         settle_ff <= '0;
         hold_ff   <= '0;
         rv_ff     <= 1'b0;
         pv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wp_ff     <= wp_in;
         held_ff   <= held_in;
         settle_ff <= settle_in;
         hold_ff   <= hold_in;
         rv_ff     <= rv_in;
         pv_ff     <= pv_in;
      end
      smp_ff  <= smp_in;
      size_ff <= size_in;
      gs_ff   <= gs_in;
      thr_ff  <= thr_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      cand_ff <= cand_in;
      lt_ff   <= lt_in;
      le_ff   <= le_in;
      med_ff  <= med_in;
      sum_ff  <= sum_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      mean_ff <= mean_in;
      res_ff  <= res_in;
      stb_ff  <= stb_in;
      rf_ff   <= rf_in;
      rs_ff   <= rs_in;
   end

   // checks
   `MBMH_ASSERT_NOW(a_div_in_wait, clock, reset, div_done, state_ff == S_DIV, "divider finished outside its wait state")
   `MBMH_ASSERT_NOW(a_rank_order, clock, reset, state_ff == S_MSCAN, lt_ff <= le_ff, "median rank counts out of order")
   `MBMH_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_chan.ready, "request taken while a request is in work")
   `MBMH_ASSERT_NOW(a_wp_range, clock, reset, 1'b1, CNT_W'(wp_ff) < CNT_W'(DEPTH), "ring write pointer beyond window")

endmodule

// File: design/mbmh_div.sv
// ----------------------------------------------------------------------------
// median band mean iterative divider
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mbmh_div #(
   parameter int unsigned N_W = 29,
   parameter int unsigned D_W = 5
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           done,
   output logic [N_W-1:0] quotient
);
   localparam int unsigned C_W = $clog2(N_W + 1);

   logic [D_W-1:0] rem_ff, rem_in;
   logic [N_W-1:0] quo_ff, quo_in;
   logic [D_W-1:0] den_ff, den_in;
   logic [C_W-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [D_W:0]   trial;
   logic           fits;

   // one restoring step
   always_comb begin
      trial   = {rem_ff, quo_ff[N_W-1]};
      fits    = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? D_W'(trial - {1'b0, den_ff}) : trial[D_W-1:0];
         quo_in = {quo_ff[N_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == C_W'(N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
